[hw/rtl/lpbd_pkg.sv]
// Shared types and status codes for the length-prefix batch deframer.
package lpbd_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;

  // Values of func on the input channel.
  localparam logic FUNC_DATA = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  // Values of result_kind on the result channel.
  localparam logic KIND_DESC    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes.
  localparam logic [StatusW-1:0] ST_OK         = 3'd0;
  localparam logic [StatusW-1:0] ST_HDR_TRUNC  = 3'd1;
  localparam logic [StatusW-1:0] ST_PAY_TRUNC  = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_PAYLOAD = 3'd3;
  localparam logic [StatusW-1:0] ST_TOO_LONG   = 3'd4;

  typedef struct packed {
    logic               result_kind;
    logic [WordW-1:0]   record_index;
    logic [WordW-1:0]   payload_offset;
    logic [WordW-1:0]   payload_len;
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   record_count;
  } result_t;

endpackage

[hw/rtl/lpbd_if.sv]
// Valid/ready channel interfaces for batch bytes and deframer results.
interface lpbd_in_if;
  import lpbd_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface lpbd_out_if;
  import lpbd_pkg::*;

  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [WordW-1:0]   record_index;
  logic [WordW-1:0]   payload_offset;
  logic [WordW-1:0]   payload_len;
  logic [StatusW-1:0] status;
  logic [WordW-1:0]   record_count;

  modport source (output valid, output result_kind, output record_index,
                  output payload_offset, output payload_len, output status,
                  output record_count, input ready);
  modport sink   (input valid, input result_kind, input record_index,
                  input payload_offset, input payload_len, input status,
                  input record_count, output ready);
endinterface

[hw/rtl/length_prefix_batch_deframer_top.sv]
// Top level of the length-prefix batch deframer: framing core plus result buffer.
// Each result is registered in the result buffer before it appears on the output channel.
// Throughput: one batch byte or end mark per cycle, limited only by the two-entry result buffer.
// Reset: synchronous, active-low rst_n clears the framing state and empties the result buffer.
module length_prefix_batch_deframer_top (
  input  logic   clk,
  input  logic   rst_n,
  lpbd_in_if.sink    in_ch,
  lpbd_out_if.source out_ch
);
  import lpbd_pkg::*;

  // Every input transfer updates the framing state in the core in the same
  // cycle. A data byte that completes a four-byte header produces a record
  // descriptor; an end mark always produces a summary and clears the state.
  logic    in_acc;
  logic    core_res_vld;
  result_t core_res;
  logic    buf_rdy;
  logic    buf_vld;
  result_t buf_res;

  // The core can always take a transfer; only the result buffer can stall it.
  // Input is refused only when both the result register and the skid
  // register hold results that are still waiting downstream.
  assign in_ch.ready = buf_rdy;
  assign in_acc      = in_ch.valid && buf_rdy;

  lpbd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .func      (in_ch.func),
    .data_byte (in_ch.data_byte),
    .res_vld   (core_res_vld),
    .res       (core_res)
  );

  lpbd_out_buf u_out_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .up_vld (core_res_vld),
    .up_res (core_res),
    .up_rdy (buf_rdy),
    .dn_vld (buf_vld),
    .dn_res (buf_res),
    .dn_rdy (out_ch.ready)
  );

  // Result channel is driven straight from the buffer's result register.
  assign out_ch.valid          = buf_vld;
  assign out_ch.result_kind    = buf_res.result_kind;
  assign out_ch.record_index   = buf_res.record_index;
  assign out_ch.payload_offset = buf_res.payload_offset;
  assign out_ch.payload_len    = buf_res.payload_len;
  assign out_ch.status         = buf_res.status;
  assign out_ch.record_count   = buf_res.record_count;

  // An end-mark transfer must always yield a summary result.
  a_end_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FUNC_END) |->
      (core_res_vld && core_res.result_kind == KIND_SUMMARY))
    else $error("end mark transfer did not produce a summary");

  // Descriptors carry neither a status nor a record count.
  a_desc_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (core_res_vld && core_res.result_kind == KIND_DESC) |->
      (core_res.status == ST_OK && core_res.record_count == '0))
    else $error("descriptor carries summary fields");

  // The input side can only stall while a result is being offered downstream.
  a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
    !buf_rdy |-> buf_vld)
    else $error("input stalled with no result on the output");

  // A result leaves the core only on an input transfer.
  a_result_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    core_res_vld |-> in_acc)
    else $error("result produced without an input transfer");

endmodule

[hw/rtl/lpbd_core.sv]
// Framing state and result generation for one accepted batch byte or end mark.
module lpbd_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         acc,
  input  logic                         func,
  input  logic [lpbd_pkg::ByteW-1:0]   data_byte,
  output logic                         res_vld,
  output lpbd_pkg::result_t            res
);
  import lpbd_pkg::*;

  logic               in_payload_r, in_payload_nxt;
  logic [1:0]         hdr_cnt_r, hdr_cnt_nxt;
  logic [23:0]        len_acc_r, len_acc_nxt;
  logic [WordW-1:0]   pay_rem_r, pay_rem_nxt;
  logic [WordW-1:0]   byte_off_r, byte_off_nxt;
  logic [WordW-1:0]   rec_cnt_r, rec_cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [WordW-1:0]   off_inc;
  logic [WordW-1:0]   full_len;
  logic [StatusW-1:0] sum_status;

  assign off_inc  = byte_off_r + 32'd1;
  assign full_len = {data_byte, len_acc_r};

  always_comb begin
    if (ovf_r) begin
      sum_status = ST_TOO_LONG;
    end else if (in_payload_r) begin
      sum_status = ST_PAY_TRUNC;
    end else if (hdr_cnt_r != 2'd0) begin
      sum_status = ST_HDR_TRUNC;
    end else if (rec_cnt_r == '0) begin
      sum_status = ST_NO_PAYLOAD;
    end else begin
      sum_status = ST_OK;
    end
  end

  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    len_acc_nxt    = len_acc_r;
    pay_rem_nxt    = pay_rem_r;
    byte_off_nxt   = byte_off_r;
    rec_cnt_nxt    = rec_cnt_r;
    ovf_nxt        = ovf_r;
    res_vld        = 1'b0;
    res            = '0;
    if (acc) begin
      if (func == FUNC_END) begin
        res_vld          = 1'b1;
        res.result_kind  = KIND_SUMMARY;
        res.status       = sum_status;
        res.record_count = rec_cnt_r;
        in_payload_nxt   = 1'b0;
        hdr_cnt_nxt      = 2'd0;
        len_acc_nxt      = '0;
        pay_rem_nxt      = '0;
        byte_off_nxt     = '0;
        rec_cnt_nxt      = '0;
        ovf_nxt          = 1'b0;
      end else if (!ovf_r) begin
        if (byte_off_r == '1) begin
          // The byte would sit past the last addressable offset.
          ovf_nxt = 1'b1;
        end else begin
          byte_off_nxt = off_inc;
          if (in_payload_r) begin
            pay_rem_nxt = pay_rem_r - 32'd1;
            if (pay_rem_r == 32'd1) begin
              in_payload_nxt = 1'b0;
            end
          end else begin
            case (hdr_cnt_r)
              2'd0: begin
                len_acc_nxt[7:0] = data_byte;
                hdr_cnt_nxt      = 2'd1;
              end
              2'd1: begin
                len_acc_nxt[15:8] = data_byte;
                hdr_cnt_nxt       = 2'd2;
              end
              2'd2: begin
                len_acc_nxt[23:16] = data_byte;
                hdr_cnt_nxt        = 2'd3;
              end
              default: begin
                res_vld            = 1'b1;
                res.result_kind    = KIND_DESC;
                res.record_index   = rec_cnt_r;
                res.payload_offset = off_inc;
                res.payload_len    = full_len;
                if (rec_cnt_r != '1) begin
                  rec_cnt_nxt = rec_cnt_r + 32'd1;
                end
                if (full_len != '0) begin
                  in_payload_nxt = 1'b1;
                  pay_rem_nxt    = full_len;
                end
                hdr_cnt_nxt = 2'd0;
                len_acc_nxt = '0;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_cnt_r    <= 2'd0;
      len_acc_r    <= '0;
      pay_rem_r    <= '0;
      byte_off_r   <= '0;
      rec_cnt_r    <= '0;
      ovf_r        <= 1'b0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      len_acc_r    <= len_acc_nxt;
      pay_rem_r    <= pay_rem_nxt;
      byte_off_r   <= byte_off_nxt;
      rec_cnt_r    <= rec_cnt_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

[hw/rtl/lpbd_out_buf.sv]
// Result register with a skid stage so the input side keeps moving under stall.
module lpbd_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_vld,
  input  lpbd_pkg::result_t up_res,
  output logic              up_rdy,
  output logic              dn_vld,
  output lpbd_pkg::result_t dn_res,
  input  logic              dn_rdy
);
  import lpbd_pkg::*;

  logic    main_vld_r, main_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;

  assign up_rdy = !skid_vld_r;
  assign dn_vld = main_vld_r;
  assign dn_res = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (!main_vld_r || dn_rdy) begin
      if (skid_vld_r) begin
        main_vld_nxt = 1'b1;
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        main_vld_nxt = up_vld;
        main_nxt     = up_res;
      end
    end else if (up_vld && up_rdy) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = up_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

[test/length_prefix_batch_deframer_top_test.sv]
// Self-checking testbench for the length-prefix batch deframer top level.
module length_prefix_batch_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpbd_pkg::*;

  // One transfer on the input channel: a batch byte or an end-of-batch mark.
  typedef struct packed {
    logic             func;
    logic [ByteW-1:0] data_byte;
  } batch_item_t;

  // Longest run of cycles with no transfer on either side before the run is
  // declared hung. The slowest legal stretch is the receiver hold-off plus a
  // long random gap, well under this figure.
  localparam int unsigned IDLE_LIMIT   = 3000;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned HOLDOFF_AT   = 300;
  localparam int unsigned HOLDOFF_LEN  = 100;

  logic clk;
  logic rst_n;

  lpbd_in_if  in_ch ();
  lpbd_out_if out_ch ();

  length_prefix_batch_deframer_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Items waiting to be offered, and results that the framer must still produce.
  batch_item_t batch_items[$];
  result_t     expected_results[$];

  // Shadow copy of the framer state, advanced once per accepted input transfer.
  logic             fr_in_payload;
  logic [1:0]       fr_hdr_seen;
  logic [WordW-1:0] fr_len_acc;
  logic [WordW-1:0] fr_pay_left;
  logic [WordW-1:0] fr_offset;
  logic [WordW-1:0] fr_records;
  logic             fr_overflow;

  // Bookkeeping shared by the clocked processes.
  bit          in_fired;
  int unsigned items_taken;
  int unsigned results_taken;
  int unsigned desc_seen;
  int unsigned status_seen[0:7];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned holdoff_left;
  bit          holdoff_done;
  int unsigned send_gap;
  int unsigned send_steady;
  int unsigned recv_gap;
  int unsigned recv_steady;

  // ---------------------------------------------------------------------------
  // Framing predictor.
  // ---------------------------------------------------------------------------

  function automatic void clear_framer();
    fr_in_payload = 1'b0;
    fr_hdr_seen   = '0;
    fr_len_acc    = '0;
    fr_pay_left   = '0;
    fr_offset     = '0;
    fr_records    = '0;
    fr_overflow   = 1'b0;
  endfunction

  // Advances the shadow state by one input transfer. Returns 1 when the transfer
  // produces a result, which is then placed in res.
  function automatic bit deframe_step(input logic fn, input logic [ByteW-1:0] b,
                                      output result_t res);
    res = '0;
    if (fn == FUNC_END) begin
      // The summary reports the worst problem seen; the byte field is ignored.
      res.result_kind = KIND_SUMMARY;
      if (fr_overflow)
        res.status = ST_TOO_LONG;
      else if (fr_in_payload)
        res.status = ST_PAY_TRUNC;
      else if (fr_hdr_seen != 2'd0)
        res.status = ST_HDR_TRUNC;
      else if (fr_records == '0)
        res.status = ST_NO_PAYLOAD;
      else
        res.status = ST_OK;
      res.record_count = fr_records;
      clear_framer();
      return 1'b1;
    end
    // Once the batch has run past the last byte offset, everything up to the
    // end mark is dropped.
    if (fr_overflow)
      return 1'b0;
    if (fr_offset == '1) begin
      fr_overflow = 1'b1;
      return 1'b0;
    end
    fr_offset = fr_offset + 1'b1;
    if (fr_in_payload) begin
      fr_pay_left = fr_pay_left - 1'b1;
      if (fr_pay_left == '0)
        fr_in_payload = 1'b0;
      return 1'b0;
    end
    // Header bytes arrive least significant first.
    fr_len_acc = fr_len_acc | (WordW'(b) << {fr_hdr_seen, 3'b000});
    if (fr_hdr_seen != 2'd3) begin
      fr_hdr_seen = fr_hdr_seen + 1'b1;
      return 1'b0;
    end
    res.result_kind    = KIND_DESC;
    res.record_index   = fr_records;
    res.payload_offset = fr_offset;
    res.payload_len    = fr_len_acc;
    if (fr_records != '1)
      fr_records = fr_records + 1'b1;
    // A zero-length record leaves the framer expecting the next header at once.
    if (fr_len_acc != '0) begin
      fr_in_payload = 1'b1;
      fr_pay_left   = fr_len_acc;
    end
    fr_hdr_seen = '0;
    fr_len_acc  = '0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [WordW-1:0] want,
                                      input logic [WordW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic void add_byte(input logic [ByteW-1:0] b);
    batch_items.push_back('{func: FUNC_DATA, data_byte: b});
  endfunction

  // The end mark carries a random byte, which the framer must ignore.
  function automatic void add_end();
    batch_items.push_back('{func: FUNC_END, data_byte: ByteW'($urandom_range(255))});
  endfunction

  function automatic void add_header(input logic [WordW-1:0] len);
    for (int i = 0; i < 4; i++)
      add_byte(len[8*i +: 8]);
  endfunction

  function automatic void add_payload(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      add_byte(ByteW'($urandom_range(255)));
  endfunction

  // Payload lengths stay short so that many records fit in the run; a few are
  // longer, up to 48 bytes.
  function automatic int unsigned pick_length();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 25)
      return 0;
    if (p < 90)
      return $urandom_range(12, 1);
    return $urandom_range(48, 13);
  endfunction

  // Gap lengths: mostly none or short, now and then long. A steady stretch
  // with no gaps at all starts from time to time.
  function automatic int unsigned pick_gap(ref int unsigned steady);
    int unsigned p;
    if (steady != 0) begin
      steady--;
      return 0;
    end
    if ($urandom_range(39) == 0) begin
      steady = $urandom_range(80, 30);
      return 0;
    end
    p = $urandom_range(99);
    if (p < 55)
      return 0;
    if (p < 85)
      return $urandom_range(3, 1);
    if (p < 97)
      return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued items at the falling edge. An item stays on the
  // channel until a transfer takes it; only then may a gap follow.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : send_proc
    batch_item_t item;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fired) begin
      // Still waiting for the current item to be taken.
    end else if (send_gap != 0 && holdoff_left == 0) begin
      send_gap--;
      in_ch.valid <= 1'b0;
    end else if (batch_items.size() != 0) begin
      item = batch_items.pop_front();
      in_ch.valid     <= 1'b1;
      in_ch.func      <= item.func;
      in_ch.data_byte <= item.data_byte;
      send_gap = pick_gap(send_steady);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls on ready, plus one long hold-off partway through
  // the random part. During the hold-off the driver suppresses its own gaps,
  // so the result buffer fills and the block must stop taking input.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin : recv_proc
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else if (!holdoff_done && items_taken >= HOLDOFF_AT) begin
      holdoff_done = 1'b1;
      holdoff_left = HOLDOFF_LEN;
      out_ch.ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      recv_gap = pick_gap(recv_steady);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, the result transfer is checked first, then the
  // input transfer is fed to the predictor. A result can never stem from an
  // input taken at the same edge, so this order is safe.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : watch_proc
    result_t got;
    result_t want;
    result_t pred;
    in_fired = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.result_kind    = out_ch.result_kind;
        got.record_index   = out_ch.record_index;
        got.payload_offset = out_ch.payload_offset;
        got.payload_len    = out_ch.payload_len;
        got.status         = out_ch.status;
        got.record_count   = out_ch.record_count;
        results_taken++;
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual %0h", $time, got);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", WordW'(want.result_kind), WordW'(got.result_kind));
          check_field("record_index", want.record_index, got.record_index);
          check_field("payload_offset", want.payload_offset, got.payload_offset);
          check_field("payload_len", want.payload_len, got.payload_len);
          check_field("status", WordW'(want.status), WordW'(got.status));
          check_field("record_count", want.record_count, got.record_count);
          if (want.result_kind == KIND_DESC)
            desc_seen++;
          else
            status_seen[want.status]++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        in_fired = 1'b1;
        items_taken++;
        if (deframe_step(in_ch.func, in_ch.data_byte, pred))
          expected_results.push_back(pred);
      end
      // Watchdog: any transfer on either side counts as progress.
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
          $display("[length_prefix_batch_deframer_top] ERROR");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------

  initial begin : stim_proc
    int unsigned n_rec;
    int unsigned p;
    int unsigned target;
    logic [WordW-1:0] big_len;

    // Every input of the block holds a known value from time zero.
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.func      = FUNC_DATA;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    in_fired        = 1'b0;
    items_taken     = 0;
    results_taken   = 0;
    desc_seen       = 0;
    error_count     = 0;
    idle_cycles     = 0;
    holdoff_left    = 0;
    holdoff_done    = 1'b0;
    send_gap        = 0;
    send_steady     = 0;
    recv_gap        = 0;
    recv_steady     = 0;
    foreach (status_seen[i])
      status_seen[i] = 0;
    clear_framer();

    // Directed part. An empty batch whose end mark carries a nonzero byte.
    batch_items.push_back('{func: FUNC_END, data_byte: 8'hFF});
    // A single zero-length record closes cleanly.
    add_header(32'h0000_0000);
    add_end();
    // Three all-ones header bytes, then the end: header cut short.
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_end();
    // A huge length with one payload byte: payload cut short.
    add_header(32'hFF80_4021);
    add_byte(8'h00);
    add_end();
    // Two records, the second of zero length, then a clean end.
    add_header(32'd2);
    add_byte(8'hA5);
    add_byte(8'h5A);
    add_header(32'd0);
    add_end();

    // Random part: mostly well-formed batches with random payloads, some cut
    // off inside a header or inside a payload.
    target = batch_items.size() + RANDOM_ITEMS;
    while (batch_items.size() < target) begin
      n_rec = $urandom_range(5);
      for (int unsigned r = 0; r < n_rec; r++) begin
        p = pick_length();
        add_header(p);
        add_payload(p);
      end
      p = $urandom_range(99);
      if (p < 10) begin
        // Cut inside the next header, with bytes of any value.
        add_payload($urandom_range(3, 1));
      end else if (p < 20) begin
        // A length far beyond what follows.
        big_len = $urandom();
        add_header(big_len);
        add_payload($urandom_range(6));
      end else if (p < 25) begin
        // A stray byte, read as a header byte.
        add_byte(ByteW'($urandom_range(255)));
      end
      add_end();
    end

    // Reset is held from time zero, then released at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every item is taken and every result has come back, then keep
    // watching the block for any stray result before the report.
    while (batch_items.size() != 0 || in_ch.valid)
      @(negedge clk);
    while (expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Run took %0d input transfers and %0d results: %0d record descriptors,",
             items_taken, results_taken, desc_seen);
    $display("batch ends ok %0d, header cut %0d, payload cut %0d, no records %0d.",
             status_seen[ST_OK], status_seen[ST_HDR_TRUNC], status_seen[ST_PAY_TRUNC],
             status_seen[ST_NO_PAYLOAD]);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[length_prefix_batch_deframer_top] OK");
    end else begin
      $display("[length_prefix_batch_deframer_top] ERROR");
    end
    $finish;
  end

endmodule
